/* hdl/ngpbc_pkg.sv */
// Shared constants, mode codes and controller/datapath interface types
// for the n-gram predictive byte coder. No dependencies.
package ngpbc_pkg;

   // Default sizing of the block.
   localparam int DEF_HASH_ENTRIES  = 65536;
   localparam int DEF_MAX_ORDER     = 6;
   localparam int DEF_POSITION_BITS = 24;

   // FNV-1a hash constants and the confidence ceiling.
   localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME  = 32'd16777619;
   localparam logic [15:0] CONF_MAX   = 16'hFFFF;

   // Coder operating modes.
   typedef enum logic [1:0] {
      MODE_XOR_ENC = 2'd0,
      MODE_XOR_DEC = 2'd1,
      MODE_EMIT    = 2'd2,
      MODE_APPLY   = 2'd3
   } coder_mode_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic clear_step;
      logic hash_step;
      logic read;
      logic weigh;
      logic select;
      logic finish;
   } ngpbc_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic clear_last;
      logic hash_last;
      logic rsp_free;
   } ngpbc_status_type;

endpackage

/* hdl/ngpbc_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module ngpbc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port share one address.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/ngpbc_datapath.sv */
// Datapath: context window, hash lanes, per-order tables, selection,
// training and the result register. Depends on ngpbc_pkg and ngpbc_ram.
module ngpbc_datapath #(
   parameter int HASH_ENTRIES  = ngpbc_pkg::DEF_HASH_ENTRIES,
   parameter int MAX_ORDER     = ngpbc_pkg::DEF_MAX_ORDER,
   parameter int POSITION_BITS = ngpbc_pkg::DEF_POSITION_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ngpbc_pkg::ngpbc_cmd_type    cmd,
   output ngpbc_pkg::ngpbc_status_type status,
   input  logic                     csr_write_enable,
   input  logic [1:0]               csr_coder_mode,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_is_correction,
   input  logic                     req_start_run,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_out_byte,
   output logic [23:0]              rsp_position,
   output logic                     rsp_mispredicted
);
   import ngpbc_pkg::*;

   localparam int IW = $clog2(HASH_ENTRIES);
   localparam int SW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int CW = $clog2(MAX_ORDER + 1);
   localparam int WW = 16 + CW;

   coder_mode_type          mode_ff, mode_in;
   logic [7:0]              data_ff;
   logic                    corr_ff;
   logic [7:0]              win_ff [MAX_ORDER];
   logic [7:0]              win_in [MAX_ORDER];
   logic [CW-1:0]           count_ff, count_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [IW-1:0]           clr_ff, clr_in;
   logic [SW-1:0]           step_ff, step_in;
   logic [31:0]             hash_ff [MAX_ORDER];
   logic [31:0]             hash_in [MAX_ORDER];
   logic [WW-1:0]           weight_ff [MAX_ORDER];
   logic [WW-1:0]           weight_in [MAX_ORDER];
   logic [7:0]              pred_ff, pred_in;
   logic [23:0]             entry_q [MAX_ORDER];
   logic [23:0]             entry_w [MAX_ORDER];
   logic [IW-1:0]           ram_addr [MAX_ORDER];
   logic                    ram_we [MAX_ORDER];
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_byte_ff, rsp_byte_in;
   logic [23:0]             rsp_pos_ff, rsp_pos_in;
   logic                    rsp_miss_ff, rsp_miss_in;
   logic [7:0]              actual;
   logic [7:0]              out_byte;
   logic                    miss;
   logic [WW-1:0]           best_w;

   // Actual byte and result byte for the current mode.
   always_comb begin
      unique case (mode_ff)
         MODE_XOR_ENC: begin
            actual   = data_ff;
            out_byte = data_ff ^ pred_ff;
         end
         MODE_XOR_DEC: begin
            actual   = data_ff ^ pred_ff;
            out_byte = actual;
         end
         MODE_EMIT: begin
            actual   = data_ff;
            out_byte = actual;
         end
         MODE_APPLY: begin
            actual   = corr_ff ? data_ff : pred_ff;
            out_byte = actual;
         end
         default: begin
            actual   = data_ff;
            out_byte = data_ff;
         end
      endcase
      miss = (actual != pred_ff);
   end

   // One table per order; lanes hash, weigh and train in parallel.
   for (genvar l = 0; l < MAX_ORDER; l++) begin : g_order
      logic [15:0] conf;
      logic [7:0]  prd;
      logic        lane_ok;

      assign conf    = entry_q[l][23:8];
      assign prd     = entry_q[l][7:0];
      assign lane_ok = (CW'(l + 1) <= count_ff);

      // Trained entry, or zero during the clearing sweep.
      always_comb begin
         if (cmd.clear_step) begin
            entry_w[l] = '0;
         end else if (prd == actual) begin
            entry_w[l] = {(conf < CONF_MAX) ? conf + 16'd1 : conf, prd};
         end else if (conf > 16'd1) begin
            entry_w[l] = {conf - 16'd1, prd};
         end else begin
            entry_w[l] = {16'd1, actual};
         end
         ram_addr[l] = cmd.clear_step ? clr_ff : hash_ff[l][IW-1:0];
         ram_we[l]   = cmd.clear_step || (cmd.finish && lane_ok);
      end

      // Hash lane: order l+1 folds in the window from slot MAX_ORDER-l-1 onwards.
      always_comb begin
         hash_in[l] = hash_ff[l];
         if (cmd.accept) begin
            hash_in[l] = FNV_OFFSET;
         end else if (cmd.hash_step && (int'(step_ff) + l + 1 >= MAX_ORDER)) begin
            hash_in[l] = (hash_ff[l] ^ {24'd0, win_ff[step_ff]}) * FNV_PRIME;
         end
         weight_in[l] = weight_ff[l];
         if (cmd.weigh) begin
            weight_in[l] = lane_ok ? WW'(conf) * WW'(l + 1) : '0;
         end
      end

      ngpbc_ram #(
         .WIDTH (24),
         .DEPTH (HASH_ENTRIES)
      ) u_table (
         .clock (clock),
         .addr  (ram_addr[l]),
         .we    (ram_we[l]),
         .wdata (entry_w[l]),
         .re    (cmd.read),
         .rdata (entry_q[l])
      );
   end

   // Pick the strictly heaviest order; ties keep the lower one.
   always_comb begin
      best_w  = '0;
      pred_in = pred_ff;
      if (cmd.select) begin
         pred_in = 8'd0;
         for (int l = 0; l < MAX_ORDER; l++) begin
            if (weight_ff[l] > best_w) begin
               best_w  = weight_ff[l];
               pred_in = entry_q[l][7:0];
            end
         end
      end
   end

   // Run state: window, fill count, position and the clearing address.
   always_comb begin
      mode_in  = csr_write_enable ? coder_mode_type'(csr_coder_mode) : mode_ff;
      win_in   = win_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      clr_in   = cmd.clear_step ? clr_ff + 1'b1 : clr_ff;
      step_in  = cmd.hash_step ? step_ff + 1'b1 : step_ff;
      if (cmd.accept) begin
         step_in = '0;
         if (req_start_run) begin
            for (int i = 0; i < MAX_ORDER; i++) begin
               win_in[i] = 8'd0;
            end
            count_in = '0;
            pos_in   = '0;
         end
      end else if (cmd.finish) begin
         for (int i = 0; i < MAX_ORDER - 1; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[MAX_ORDER - 1] = actual;
         if (count_ff < CW'(MAX_ORDER)) begin
            count_in = count_ff + 1'b1;
         end
         pos_in = pos_ff + 1'b1;
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_miss_in  = rsp_miss_ff;
      if (cmd.finish && !(mode_ff == MODE_EMIT && !miss)) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = out_byte;
         rsp_pos_in   = 24'(pos_ff);
         rsp_miss_in  = miss;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_XOR_ENC;
         count_ff     <= '0;
         pos_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_ORDER; i++) begin
            win_ff[i] <= 8'd0;
         end
      end else begin
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         win_ff       <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         data_ff <= req_data_byte;
         corr_ff <= req_is_correction;
      end
      step_ff     <= step_in;
      hash_ff     <= hash_in;
      weight_ff   <= weight_in;
      pred_ff     <= pred_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_miss_ff <= rsp_miss_in;
   end

   assign status.clear_last = &clr_ff;
   assign status.hash_last  = (step_ff == SW'(MAX_ORDER - 1));
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_mispredicted = rsp_miss_ff;

endmodule

/* hdl/ngpbc_ctrl.sv */
// Controller state machine sequencing clear, hash, lookup, select and train.
// Depends on ngpbc_pkg.
module ngpbc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_start_run,
   input  ngpbc_pkg::ngpbc_status_type status,
   output ngpbc_pkg::ngpbc_cmd_type    cmd
);
   import ngpbc_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_READ,
      ST_WEIGH,
      ST_SELECT,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      pending_ff, pending_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      pending_in = pending_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in   = pending_ff ? ST_HASH : ST_IDLE;
               pending_in = 1'b0;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_start_run) begin
                  state_in   = ST_CLEAR;
                  pending_in = 1'b1;
               end else begin
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            cmd.hash_step = 1'b1;
            if (status.hash_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_WEIGH;
         end
         ST_WEIGH: begin
            cmd.weigh = 1'b1;
            state_in  = ST_SELECT;
         end
         ST_SELECT: begin
            cmd.select = 1'b1;
            state_in   = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
      end
   end

   // A result is only written when the output register can take it.
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.rsp_free)
      else $error("finish issued while result register busy");

   // An accepted word always starts a clear or a hash.
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_HASH || state_ff == ST_CLEAR))
      else $error("accepted word not processed");

   // The last hash step is followed by the table lookup.
   a_hash_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HASH && status.hash_last) |=> state_ff == ST_READ)
      else $error("hash did not lead to lookup");

endmodule

/* hdl/ngram_predictive_byte_coder_core.sv */
// Top level of the n-gram predictive byte coder.
// Depends on ngpbc_pkg, ngpbc_ctrl and ngpbc_datapath.
//
// One byte word is taken at a time. Each word passes through MAX_ORDER
// steps of the hash lanes, one registered table read, weighting, selection
// and a final step that writes the result and trains the order tables whose
// context is filled, then the core is ready again. The tables are cleared by
// a sweep over all HASH_ENTRIES addresses (65536 by default) after reset and
// before any word that starts a run; no word is taken while it runs. The next
// word is accepted while a result still waits to be taken, but the final step
// of that word waits until the result register is free.
module ngram_predictive_byte_coder_core #(
   parameter int HASH_ENTRIES  = ngpbc_pkg::DEF_HASH_ENTRIES,
   parameter int MAX_ORDER     = ngpbc_pkg::DEF_MAX_ORDER,
   parameter int POSITION_BITS = ngpbc_pkg::DEF_POSITION_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_coder_mode,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_is_correction,
   input  logic        req_start_run,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic [23:0] rsp_position,
   output logic        rsp_mispredicted
);
   import ngpbc_pkg::*;

   ngpbc_cmd_type    cmd;
   ngpbc_status_type status;

   // Sequencer.
   ngpbc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_start_run (req_start_run),
      .status        (status),
      .cmd           (cmd)
   );

   // Tables, hashing and result path.
   ngpbc_datapath #(
      .HASH_ENTRIES  (HASH_ENTRIES),
      .MAX_ORDER     (MAX_ORDER),
      .POSITION_BITS (POSITION_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write_enable  (csr_write_enable),
      .csr_coder_mode    (csr_coder_mode),
      .req_data_byte     (req_data_byte),
      .req_is_correction (req_is_correction),
      .req_start_run     (req_start_run),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_position      (rsp_position),
      .rsp_mispredicted  (rsp_mispredicted)
   );

endmodule

/* verif/tb_ngram_predictive_byte_coder_core.sv */
// Self-checking testbench for ngram_predictive_byte_coder_core: random and directed
// byte words are checked against a built-in predictor of the hashed-context coder.
// Depends on ngpbc_pkg and the core RTL.
module tb_ngram_predictive_byte_coder_core;
   timeunit 1ns;
   timeprecision 1ps;
   import ngpbc_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      bit [7:0] data_byte;
      bit       is_correction;
      bit       start_run;
   } byte_word_type;

   typedef struct {
      bit [7:0]  out_byte;
      bit [23:0] position;
      bit        mispredicted;
   } coded_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_coder_mode = MODE_XOR_ENC;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_is_correction = 1'b0;
   logic        req_start_run = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [23:0] rsp_position;
   logic        rsp_mispredicted;

   byte_word_type  pending_words[$];
   coded_word_type expected_codes[$];
   int             mismatch_count = 0;
   int             cycle_count = 0;
   bit             quiet = 1'b0;

   // Predictor state: context window, order tables and position.
   coder_mode_type mode_now = MODE_XOR_ENC;
   bit [7:0]       window[6];
   int             window_fill;
   bit [7:0]       guess_table[int];
   bit [15:0]      trust_table[int];
   bit [23:0]      run_position;

   ngram_predictive_byte_coder_core DUT (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_coder_mode(csr_coder_mode),
      .req_valid(req_valid), .req_ready(req_ready), .req_data_byte(req_data_byte),
      .req_is_correction(req_is_correction), .req_start_run(req_start_run),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_out_byte(rsp_out_byte),
      .rsp_position(rsp_position), .rsp_mispredicted(rsp_mispredicted)
   );

   always #4 clock = ~clock;

   function automatic void clear_run();
      foreach (window[i]) window[i] = 8'd0;
      window_fill = 0;
      guess_table.delete();
      trust_table.delete();
      run_position = 24'd0;
   endfunction

   // Table slot of order k: FNV-1a over the last k bytes, oldest first.
   function automatic int context_slot(int k);
      bit [31:0] h;
      h = FNV_OFFSET;
      for (int i = window_fill - k; i < window_fill; i++) begin
         h = (h ^ {24'd0, window[i]}) * FNV_PRIME;
      end
      return (k - 1) * 65536 + int'(h[15:0]);
   endfunction

   function automatic bit [7:0] forecast();
      bit [7:0]  best;
      bit [31:0] best_weight;
      bit [31:0] weight;
      int        s;
      best = 8'd0;
      best_weight = 0;
      for (int k = 1; k <= window_fill; k++) begin
         s = context_slot(k);
         weight = trust_table.exists(s) ? k * trust_table[s] : 0;
         if (weight > best_weight) begin
            best_weight = weight;
            best = guess_table[s];
         end
      end
      return best;
   endfunction

   function automatic void train_tables(bit [7:0] actual);
      int        s;
      bit [7:0]  g;
      bit [15:0] c;
      for (int k = 1; k <= window_fill; k++) begin
         s = context_slot(k);
         g = guess_table.exists(s) ? guess_table[s] : 8'd0;
         c = trust_table.exists(s) ? trust_table[s] : 16'd0;
         if (g == actual) begin
            if (c != CONF_MAX) c++;
         end else if (c > 1) begin
            c--;
         end else begin
            g = actual;
            c = 16'd1;
         end
         guess_table[s] = g;
         trust_table[s] = c;
      end
   endfunction

   // Works out the coded word (if any) for one accepted byte word.
   function automatic void code_byte(byte_word_type w);
      bit [7:0]       guess;
      bit [7:0]       actual;
      coded_word_type r;
      if (w.start_run) clear_run();
      guess = forecast();
      case (mode_now)
         MODE_XOR_ENC: begin
            actual = w.data_byte;
            r.out_byte = actual ^ guess;
         end
         MODE_XOR_DEC: begin
            actual = w.data_byte ^ guess;
            r.out_byte = actual;
         end
         MODE_EMIT: begin
            actual = w.data_byte;
            r.out_byte = actual;
         end
         default: begin
            actual = w.is_correction ? w.data_byte : guess;
            r.out_byte = actual;
         end
      endcase
      r.mispredicted = (actual != guess);
      r.position = run_position;
      if (!(mode_now == MODE_EMIT && !r.mispredicted)) expected_codes.push_back(r);
      train_tables(actual);
      if (window_fill < 6) begin
         window[window_fill] = actual;
         window_fill++;
      end else begin
         for (int i = 0; i < 5; i++) window[i] = window[i + 1];
         window[5] = actual;
      end
      run_position = run_position + 24'd1;
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
   endtask

   // Driver: offers queued words, with random bursts of idle cycles.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            code_byte('{req_data_byte, req_is_correction, req_start_run});
         end
         if (!(req_valid && !req_ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               byte_word_type w;
               w = pending_words.pop_front();
               req_data_byte <= w.data_byte;
               req_is_correction <= w.is_correction;
               req_start_run <= w.start_run;
               req_valid <= 1'b1;
               if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 15);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each taken result word against the oldest expectation.
   int stall_left = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_codes.size() == 0) begin
               report_mismatch($sformatf("unexpected result at position %0d", rsp_position));
            end else begin
               coded_word_type e;
               e = expected_codes.pop_front();
               if (rsp_out_byte !== e.out_byte)
                  report_mismatch($sformatf("out_byte %0h, expected %0h (position %0d)",
                                            rsp_out_byte, e.out_byte, e.position));
               if (rsp_position !== e.position)
                  report_mismatch($sformatf("position %0d, expected %0d",
                                            rsp_position, e.position));
               if (rsp_mispredicted !== e.mispredicted)
                  report_mismatch($sformatf("mispredicted %0b, expected %0b (position %0d)",
                                            rsp_mispredicted, e.mispredicted, e.position));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic add_word(bit [7:0] d, bit c, bit s);
      pending_words.push_back('{d, c, s});
   endtask

   // Mostly repeated patterns so that the tables learn; some noise on top.
   task automatic add_random_words(int count, bit restart);
      bit [7:0] pattern[16];
      int       len;
      int       n;
      n = 0;
      while (n < count) begin
         len = $urandom_range(2, 12);
         foreach (pattern[i]) pattern[i] = $urandom_range(0, 7) == 0 ?
                                           8'($urandom) : 8'($urandom_range(60, 70));
         for (int rep = $urandom_range(1, 8); rep > 0 && n < count; rep--) begin
            for (int i = 0; i < len && n < count; i++) begin
               bit [7:0] d;
               bit       c;
               d = ($urandom_range(0, 15) == 0) ? 8'($urandom) : pattern[i];
               c = $urandom_range(0, 4) == 0;
               if (mode_now == MODE_XOR_DEC && $urandom_range(0, 3) != 0) d = 8'd0;
               add_word(d, c, restart && n == 0);
               n++;
            end
         end
      end
   endtask

   // Waits until every word is taken and every result has come back.
   task automatic drain();
      do @(negedge clock);
      while (pending_words.size() > 0 || req_valid || expected_codes.size() > 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_mode(coder_mode_type m);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_coder_mode <= m;
      mode_now = m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      coder_mode_type plan[6];
      bit             restart[6];
      clear_run();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed opening in encode mode: byte extremes, a learnt pattern,
      // and the correction flag, which encode mode ignores.
      set_mode(MODE_XOR_ENC);
      add_word(8'hFF, 1'b0, 1'b1);
      add_word(8'h00, 1'b1, 1'b0);
      for (int i = 0; i < 6; i++) begin
         add_word(8'h41, 1'b0, 1'b0);
         add_word(8'h42, 1'b1, 1'b0);
         add_word(8'hAA, 1'b0, 1'b0);
      end
      add_word(8'h55, 1'b0, 1'b0);
      drain();

      // Apply mode: corrections, with one uncorrected word that takes the prediction.
      set_mode(MODE_APPLY);
      add_word(8'h41, 1'b1, 1'b0);
      add_word(8'h42, 1'b1, 1'b0);
      add_word(8'h00, 1'b0, 1'b0);
      add_word(8'hFF, 1'b1, 1'b0);
      drain();

      // Random phases; modes change both within a run and with a fresh run.
      plan = '{MODE_XOR_DEC, MODE_EMIT, MODE_APPLY, MODE_XOR_ENC, MODE_EMIT, MODE_APPLY};
      restart = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      foreach (plan[p]) begin
         set_mode(plan[p]);
         if (p == 5) quiet = 1'b1;
         add_random_words(320, restart[p]);
         drain();
      end

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
